FILE: rtl/uart_pkg.sv
// ----------------------------------------------------------------------------
// uart_pkg: shared types and constants for the 8N1 UART
// Op and status codes, field widths and the result structs that pass
// between the transmit half, the receive half and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package uart_pkg;

  // Field and register widths
  localparam int unsigned TPB_W  = 20;  // ticks per bit
  localparam int unsigned TPU_W  = 10;  // ticks per microsecond
  localparam int unsigned TMO_W  = 24;  // timeout in microseconds
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RXC_W  = TPB_W + 1;      // 1.5 bit times
  localparam int unsigned TMR_W  = TMO_W + TPU_W;  // timeout in ticks

  // Register reset values
  localparam logic [TPB_W-1:0] TPB_RESET = TPB_W'(6076);
  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(700);

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_BIT  = 1'b0;
  localparam logic CFG_TICKS_PER_USEC = 1'b1;

  // Per-tick operation; code 3 acts as a plain tick
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SEND = 2'd1,
    OP_ARM  = 2'd2
  } op_e;

  // Receive status
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_BYTE    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_FRAME   = 2'd3
  } rx_status_e;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic              busy;
    rx_status_e        status;
    logic [BYTE_W-1:0] data;
  } rx_res_t;

endpackage

`default_nettype wire

FILE: rtl/uart_tx.sv
// ----------------------------------------------------------------------------
// uart_tx: transmit half
// Advances one tick per step. Sends start, data LSB first, stop; the start
// bit is driven on the same tick that the send request arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_tx #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [1:0]                    op_i,
  input  wire logic [uart_pkg::BYTE_W-1:0]   send_byte_i,
  input  wire logic [uart_pkg::TPB_W-1:0]    bit_time_i,
  output uart_pkg::tx_res_t                  res_o
);

  localparam int unsigned PH_W = $clog2(DATA_BITS + 3);
  localparam logic [PH_W-1:0] PH_IDLE  = PH_W'(0);
  localparam logic [PH_W-1:0] PH_START = PH_W'(1);
  localparam logic [PH_W-1:0] PH_STOP  = PH_W'(DATA_BITS + 2);

  logic [PH_W-1:0]               phase_q, phase_d;
  logic [DATA_BITS-1:0]          shift_q, shift_d;
  logic [uart_pkg::TPB_W-1:0]    cnt_q, cnt_d;

  logic                          start;
  logic [PH_W-1:0]               cur_phase;
  logic [DATA_BITS-1:0]          cur_shift;
  logic [uart_pkg::TPB_W-1:0]    cnt_inc;
  logic [DATA_BITS+7:0]          byte_ext;

  assign byte_ext = {{DATA_BITS{1'b0}}, send_byte_i};

  // Next state for one tick
  always_comb begin
    start     = (phase_q == PH_IDLE) && (op_i == uart_pkg::OP_SEND);
    cur_phase = start ? PH_START : phase_q;
    cur_shift = start ? byte_ext[DATA_BITS-1:0] : shift_q;
    cnt_inc   = (start ? '0 : cnt_q) + 1'b1;

    phase_d   = cur_phase;
    shift_d   = cur_shift;
    cnt_d     = start ? '0 : cnt_q;
    res_o.line = 1'b1;
    res_o.busy = 1'b0;

    if (cur_phase != PH_IDLE) begin
      res_o.busy = 1'b1;
      if (cur_phase == PH_START) begin
        res_o.line = 1'b0;
      end else if (cur_phase < PH_STOP) begin
        res_o.line = cur_shift[0];
      end
      cnt_d = cnt_inc;
      // bit time done: next bit, shift after a data bit
      if (cnt_inc >= bit_time_i) begin
        cnt_d = '0;
        if (cur_phase != PH_START && cur_phase < PH_STOP) begin
          shift_d = cur_shift >> 1;
        end
        phase_d = (cur_phase == PH_STOP) ? PH_IDLE : cur_phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uart_rx.sv
// ----------------------------------------------------------------------------
// uart_rx: receive half
// Armed by an op, waits for a low line with a tick timeout, samples data
// at 1.5 bit times and then every bit time, checks the stop bit.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [1:0]                    op_i,
  input  wire logic [uart_pkg::TMO_W-1:0]    wait_us_i,
  input  wire logic                          rx_level_i,
  input  wire logic [uart_pkg::TPB_W-1:0]    bit_time_i,
  input  wire logic [uart_pkg::TPU_W-1:0]    ticks_per_usec_i,
  output uart_pkg::rx_res_t                  res_o
);

  localparam int unsigned PH_W = $clog2(DATA_BITS + 3);
  localparam logic [PH_W-1:0] PH_IDLE  = PH_W'(0);
  localparam logic [PH_W-1:0] PH_WAIT  = PH_W'(1);
  localparam logic [PH_W-1:0] PH_DATA0 = PH_W'(2);
  localparam logic [PH_W-1:0] PH_STOP  = PH_W'(DATA_BITS + 2);

  logic [PH_W-1:0]               phase_q, phase_d;
  logic [DATA_BITS-1:0]          shift_q, shift_d;
  logic [uart_pkg::RXC_W-1:0]    cnt_q, cnt_d;
  logic [uart_pkg::TMR_W-1:0]    elapsed_q, elapsed_d;
  logic [uart_pkg::TMR_W-1:0]    limit_q, limit_d;

  logic                          arm;
  logic                          expired;
  logic [uart_pkg::RXC_W-1:0]    first_wait;
  logic [DATA_BITS+7:0]          shift_ext;

  // 1.5 bit times to the middle of data bit 0
  assign first_wait = {1'b0, bit_time_i} + {2'b00, bit_time_i[uart_pkg::TPB_W-1:1]};
  assign shift_ext  = {8'h00, shift_q};

  always_comb begin
    arm     = (phase_q == PH_IDLE) && (op_i == uart_pkg::OP_ARM);
    // on the arm tick the product is zero exactly when a factor is
    expired = arm ? ((wait_us_i == '0) || (ticks_per_usec_i == '0))
                  : (elapsed_q == limit_q);

    phase_d      = phase_q;
    shift_d      = arm ? '0 : shift_q;
    cnt_d        = cnt_q;
    elapsed_d    = elapsed_q;
    limit_d      = arm ? uart_pkg::TMR_W'(wait_us_i) * uart_pkg::TMR_W'(ticks_per_usec_i)
                       : limit_q;
    res_o.status = uart_pkg::ST_NONE;
    res_o.data   = '0;

    if (arm || phase_q == PH_WAIT) begin
      // waiting for a start bit
      if (expired) begin
        res_o.status = uart_pkg::ST_TIMEOUT;
        phase_d      = PH_IDLE;
      end else if (!rx_level_i) begin
        phase_d = PH_DATA0;
        shift_d = '0;
        cnt_d   = first_wait;
      end else begin
        phase_d   = PH_WAIT;
        elapsed_d = (arm ? '0 : elapsed_q) + 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      // sampling data and stop bits
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == uart_pkg::RXC_W'(1)) begin
        if (phase_q < PH_STOP) begin
          shift_d = {rx_level_i, shift_q[DATA_BITS-1:1]};
          phase_d = phase_q + 1'b1;
          cnt_d   = {1'b0, bit_time_i};
        end else begin
          if (rx_level_i) begin
            res_o.status = uart_pkg::ST_BYTE;
            res_o.data   = shift_ext[7:0];
          end else begin
            res_o.status = uart_pkg::ST_FRAME;
          end
          phase_d = PH_IDLE;
        end
      end
    end
    res_o.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      shift_q   <= '0;
      cnt_q     <= '0;
      elapsed_q <= '0;
      limit_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uart_8n1_transceiver.sv
// ----------------------------------------------------------------------------
// uart_8n1_transceiver: 8N1 UART stepped one tick per input word
// Each input word is one clock tick of the serial timing; each yields one
// output word with the line, busy flags and receive status.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                 Contents
//  s_axis    in   tvalid/tready             op, byte, timeout, rx line
//  m_axis    out  tvalid/tready             tx line, busy flags, rx result
//  cfg       in   cfg_we_i (no wait)        ticks_per_bit, ticks_per_usec
//
//  One word per cycle while s_axis_tready is high: each accepted word updates
//  both halves at the accepting edge, and its result is written there into the
//  output register, or into the skid entry if the output register is stalled.
//  A two-entry output buffer (register plus skid) still takes a word during a
//  stall cycle; s_axis_tready drops while both entries are full and returns
//  the cycle after the skid entry moves on.
//  Reset clears both halves to idle and the registers to 6076 / 700.
//
`default_nettype none

module uart_8n1_transceiver #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // send_byte[7:0], wait_us[31:8],
                                           // rx_level[32], zero[39:33]
  input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
  // result words
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // tx_line[0], tx_busy[1], rx_busy[2],
                                           // rx_byte[10:3], zero[15:11]
  output      logic [1:0]  m_axis_tuser,   // rx_status[1:0]
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [19:0] cfg_wdata_i
);

  typedef struct packed {
    uart_pkg::tx_res_t tx;
    uart_pkg::rx_res_t rx;
  } out_t;

  logic [uart_pkg::TPB_W-1:0] tpb_q;
  logic [uart_pkg::TPU_W-1:0] tpu_q;
  logic [uart_pkg::TPB_W-1:0] bit_time;

  logic              s_fire, m_fire;
  uart_pkg::tx_res_t tx_res;
  uart_pkg::rx_res_t rx_res;
  out_t              res;
  out_t              out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q <= uart_pkg::TPB_RESET;
      tpu_q <= uart_pkg::TPU_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        uart_pkg::CFG_TICKS_PER_BIT:  tpb_q <= cfg_wdata_i;
        uart_pkg::CFG_TICKS_PER_USEC: tpu_q <= cfg_wdata_i[uart_pkg::TPU_W-1:0];
        default: ;
      endcase
    end
  end

  // a bit time of zero acts as one
  assign bit_time = (tpb_q == '0) ? uart_pkg::TPB_W'(1) : tpb_q;

  assign s_axis_tready = !skid_valid_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_valid_q && m_axis_tready;

  uart_tx #(
    .DATA_BITS (DATA_BITS)
  ) u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s_fire),
    .op_i        (s_axis_tuser),
    .send_byte_i (s_axis_tdata[7:0]),
    .bit_time_i  (bit_time),
    .res_o       (tx_res)
  );

  uart_rx #(
    .DATA_BITS (DATA_BITS)
  ) u_rx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s_fire),
    .op_i             (s_axis_tuser),
    .wait_us_i        (s_axis_tdata[31:8]),
    .rx_level_i       (s_axis_tdata[32]),
    .bit_time_i       (bit_time),
    .ticks_per_usec_i (tpu_q),
    .res_o            (rx_res)
  );

  assign res = '{tx: tx_res, rx: rx_res};

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (s_fire) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_fire) begin
        out_q <= skid_q;
      end
    end else if (s_fire) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.rx.data, out_q.rx.busy, out_q.tx.busy, out_q.tx.line};
  assign m_axis_tuser  = out_q.rx.status;

  // buffer ordering: skid only holds a word behind the output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // stalled output plus new word must fill the skid entry
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && out_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("word accepted under stall was not buffered");

  // idle transmitter holds the line high
  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.tx.busy) |-> out_q.tx.line)
    else $error("idle transmitter drove the line low");

  // a reported receive result ends the receive
  a_rx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx.status != uart_pkg::ST_NONE) |-> !out_q.rx.busy)
    else $error("receiver busy after reporting a result");

  // byte data only with a good receive
  a_rx_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx.status != uart_pkg::ST_BYTE) |-> (out_q.rx.data == '0))
    else $error("receive byte nonzero without a good receive");

endmodule

`default_nettype wire

FILE: test/uart_8n1_transceiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_tb: self-checking bench for the 8N1 UART
// Streams one word per serial tick into the block. The transmit half gets send
// requests, and the receive half gets arm requests and a generated serial line
// that carries framed bytes, bad stop bits and glitches. A tick-accurate
// tracker predicts every result word. Both stream sides idle at random, and
// the bit time and timeout scale change between bursts of traffic.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_tb;

  localparam int unsigned DATA_BITS = 8;
  localparam logic [1:0]  OP_SPARE  = 2'd3;  // unused op code, acts as a plain tick

  // Frame phases of both halves
  localparam logic [3:0] TX_IDLE  = 4'd0;
  localparam logic [3:0] TX_START = 4'd1;
  localparam logic [3:0] TX_DATA0 = 4'd2;
  localparam logic [3:0] TX_STOP  = 4'(DATA_BITS + 2);
  localparam logic [3:0] RX_IDLE  = 4'd0;
  localparam logic [3:0] RX_WAIT  = 4'd1;
  localparam logic [3:0] RX_DATA0 = 4'd2;
  localparam logic [3:0] RX_STOP  = 4'(DATA_BITS + 2);

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // send_byte[7:0], wait_us[31:8], rx_level[32], zero[39:33]
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // tx_line[0], tx_busy[1], rx_busy[2], rx_byte[10:3], zero[15:11]
  logic [1:0]  m_axis_tuser;   // rx_status[1:0]
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [19:0] cfg_wdata_i;

  uart_8n1_transceiver #(
    .DATA_BITS(DATA_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  typedef struct packed {
    logic                        line;
    logic                        tx_busy;
    logic                        rx_busy;
    uart_pkg::rx_status_e        status;
    logic [uart_pkg::BYTE_W-1:0] data;
  } tick_result_t;

  // Tick-accurate tracker of both UART halves plus the queue of expected words
  class uart_tick_tracker;
    logic [19:0]  bit_ticks;
    logic [9:0]   usec_ticks;
    logic [3:0]   tx_phase;
    logic [7:0]   tx_shift;
    logic [19:0]  tx_count;
    logic [3:0]   rx_phase;
    logic [7:0]   rx_shift;
    logic [20:0]  rx_count;
    logic [33:0]  rx_wait_left;
    tick_result_t expected_ticks[$];
    int unsigned  errors, checked, n_sends, n_bytes, n_timeouts, n_frame_errs;

    function new();
      bit_ticks    = uart_pkg::TPB_RESET;
      usec_ticks   = uart_pkg::TPU_RESET;
      tx_phase     = TX_IDLE;
      tx_shift     = '0;
      tx_count     = '0;
      rx_phase     = RX_IDLE;
      rx_shift     = '0;
      rx_count     = '0;
      rx_wait_left = '0;
    endfunction

    function void set_reg(logic addr, logic [19:0] value);
      if (addr == uart_pkg::CFG_TICKS_PER_BIT) bit_ticks = value;
      else usec_ticks = value[9:0];
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction

    // Advance both halves by one accepted tick word
    function void apply_tick(logic [1:0] op, logic [7:0] send_byte, logic [23:0] tmo,
                             logic lvl);
      tick_result_t r;
      logic [19:0]  n;
      n         = (bit_ticks == '0) ? 20'd1 : bit_ticks;
      r.line    = 1'b1;
      r.tx_busy = 1'b0;
      r.status  = uart_pkg::ST_NONE;
      r.data    = '0;

      // transmitter: start bit goes out on the request tick itself
      if (tx_phase == TX_IDLE && op == uart_pkg::OP_SEND) begin
        tx_phase = TX_START;
        tx_shift = send_byte;
        tx_count = '0;
        n_sends++;
      end
      if (tx_phase != TX_IDLE) begin
        r.tx_busy = 1'b1;
        if (tx_phase == TX_START) r.line = 1'b0;
        else if (tx_phase < TX_STOP) r.line = tx_shift[tx_phase - TX_DATA0];
        else r.line = 1'b1;
        tx_count = tx_count + 20'd1;
        if (tx_count >= n) begin
          tx_count = '0;
          if (tx_phase == TX_STOP) tx_phase = TX_IDLE;
          else tx_phase = tx_phase + 4'd1;
        end
      end

      // receiver: line is already looked at on the arm tick
      if (rx_phase == RX_IDLE && op == uart_pkg::OP_ARM) begin
        rx_phase     = RX_WAIT;
        rx_wait_left = 34'(tmo) * 34'(usec_ticks);
        rx_shift     = '0;
      end
      if (rx_phase == RX_WAIT) begin
        if (rx_wait_left == '0) begin
          r.status = uart_pkg::ST_TIMEOUT;
          rx_phase = RX_IDLE;
        end else if (!lvl) begin
          rx_phase = RX_DATA0;
          rx_shift = '0;
          rx_count = 21'(n) + 21'(n >> 1);  // middle of data bit 0
        end else begin
          rx_wait_left = rx_wait_left - 34'd1;
        end
      end else if (rx_phase >= RX_DATA0) begin
        rx_count = rx_count - 21'd1;
        if (rx_count == '0) begin
          if (rx_phase < RX_STOP) begin
            if (lvl) rx_shift[rx_phase - RX_DATA0] = 1'b1;
            rx_phase = rx_phase + 4'd1;
            rx_count = 21'(n);
          end else begin
            if (lvl) begin
              r.status = uart_pkg::ST_BYTE;
              r.data   = rx_shift;
            end else begin
              r.status = uart_pkg::ST_FRAME;
            end
            rx_phase = RX_IDLE;
          end
        end
      end
      r.rx_busy = (rx_phase != RX_IDLE);
      expected_ticks.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    // Compare one result word against the oldest prediction
    function void check_tick(logic [15:0] tdata, logic [1:0] tuser);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none, got tdata %h tuser %h",
                 $time, tdata, tuser);
        return;
      end
      want = expected_ticks.pop_front();
      checked++;
      case (want.status)
        uart_pkg::ST_BYTE:    n_bytes++;
        uart_pkg::ST_TIMEOUT: n_timeouts++;
        uart_pkg::ST_FRAME:   n_frame_errs++;
        default:              ;
      endcase
      compare_field("tx_line", 8'(want.line), 8'(tdata[0]));
      compare_field("tx_busy", 8'(want.tx_busy), 8'(tdata[1]));
      compare_field("rx_busy", 8'(want.rx_busy), 8'(tdata[2]));
      compare_field("rx_byte", want.data, tdata[10:3]);
      compare_field("rx_status", 8'(want.status), 8'(tuser));
    endfunction
  endclass

  uart_tick_tracker tracker = new();

  int unsigned cur_tpb;      // bit time the serial line generator uses
  bit          send_steady;  // stretches with no input gaps
  bit          take_steady;  // stretches with no output stalls
  int unsigned line_gap, line_bit, line_hold;
  logic [9:0]  line_frame;   // stop, data LSB first, start
  int unsigned words_sent;

  function automatic int unsigned send_wait();
    if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
    return send_steady ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int unsigned take_wait();
    if ($urandom_range(0, 29) == 0) take_steady = !take_steady;
    return take_steady ? 0 : $urandom_range(0, 16);
  endfunction

  // Next serial frame on the receive line; about one in six has a low stop bit
  function automatic void new_line_frame();
    logic stop_ok;
    stop_ok    = ($urandom_range(0, 5) != 0);
    line_frame = {stop_ok, 8'($urandom), 1'b0};
    line_bit   = 0;
    line_hold  = cur_tpb;
    line_gap   = $urandom_range(0, 3 * cur_tpb);
  endfunction

  function automatic logic next_line_level();
    logic lvl;
    if (line_gap != 0) begin
      line_gap--;
      return ($urandom_range(0, 39) != 0);  // rare glitch low on the idle line
    end
    lvl = line_frame[line_bit];
    line_hold--;
    if (line_hold == 0) begin
      line_hold = cur_tpb;
      line_bit++;
      if (line_bit == 10) new_line_frame();
    end
    return lvl;
  endfunction

  // Offer one tick word and wait for the handshake
  task automatic push_word(logic [1:0] op, logic [7:0] send_byte, logic [23:0] tmo,
                           logic lvl);
    int unsigned gap;
    gap = send_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, lvl, tmo, send_byte};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_tick(op, send_byte, tmo, lvl);
    words_sent++;
  endtask

  task automatic random_word(bit line_live);
    int unsigned pick;
    logic [1:0]  op;
    logic [23:0] tmo;
    logic        lvl;
    pick = $urandom_range(0, 99);
    if (pick < 12) op = uart_pkg::OP_SEND;
    else if (pick < 30) op = uart_pkg::OP_ARM;
    else if (pick < 34) op = OP_SPARE;
    else op = uart_pkg::OP_TICK;
    // mostly short timeouts so they expire during idle gaps
    pick = $urandom_range(0, 19);
    if (pick < 12) tmo = 24'($urandom_range(0, 8));
    else if (pick < 17) tmo = 24'($urandom_range(0, 63));
    else tmo = 24'($urandom);
    lvl = line_live ? next_line_level() : 1'b1;
    push_word(op, 8'($urandom), tmo, lvl);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // one register write, then the write enable drops again before the task returns
  task automatic write_reg(logic addr, logic [19:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(addr, value);
    @(posedge clk_i);
  endtask

  // One burst of traffic at a fixed bit time and timeout scale.
  // A slow setting keeps the receive line high so no reception gets stuck
  // counting a huge bit time.
  task automatic run_phase(logic [19:0] tpb, logic [9:0] tpu, int unsigned count, bit slow);
    drain();
    write_reg(uart_pkg::CFG_TICKS_PER_BIT, tpb);
    write_reg(uart_pkg::CFG_TICKS_PER_USEC, tpu);
    cur_tpb = tpb;
    new_line_frame();
    line_gap = 0;  // first frame lands on a receiver left waiting
    repeat (count) random_word(!slow);
    // quiet line so any reception in progress ends before the bit time changes
    if (!slow)
      repeat (12 * cur_tpb + 4)
        push_word(uart_pkg::OP_TICK, 8'($urandom), 24'($urandom), 1'b1);
  endtask

  // Result side: random stalls, check every word taken
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = take_wait();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_tick(m_axis_tdata, m_axis_tuser);
    end
  end

  // Stimulus
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= uart_pkg::OP_TICK;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= uart_pkg::CFG_TICKS_PER_BIT;
    cfg_wdata_i   <= '0;
    words_sent    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero timeout, busy requests, spare op, longest timeout
    cur_tpb = uart_pkg::TPB_RESET;
    push_word(uart_pkg::OP_ARM, 8'h00, 24'h000000, 1'b1);    // times out on the arm tick
    push_word(uart_pkg::OP_SEND, 8'hFF, 24'hFFFFFF, 1'b1);
    push_word(uart_pkg::OP_SEND, 8'h00, 24'h000000, 1'b0);   // ignored, frame in progress
    push_word(OP_SPARE, 8'h5A, 24'hA5A5A5, 1'b1);
    push_word(uart_pkg::OP_ARM, 8'hA5, 24'hFFFFFF, 1'b1);    // waits for a start bit
    push_word(uart_pkg::OP_ARM, 8'h00, 24'h000000, 1'b1);    // ignored, receiver waiting
    push_word(uart_pkg::OP_TICK, 8'h3C, 24'h5A5A5A, 1'b1);

    run_phase(20'd2, 10'd1, 130, 1'b0);
    run_phase(20'hFFFFF, 10'd1023, 12, 1'b1);
    run_phase(20'd3, 10'd2, 120, 1'b0);
    run_phase(20'($urandom_range(2, 5)), 10'($urandom_range(1, 3)), 120, 1'b0);
    run_phase(20'd4, 10'd1023, 110, 1'b0);

    drain();
    repeat (4) @(posedge clk_i);
    $display("%0d tick words over six bit-time settings; %0d frames sent, %0d bytes received,",
             words_sent, tracker.n_sends, tracker.n_bytes);
    $display("%0d receive timeouts, %0d framing errors; %0d words checked, %0d mismatches",
             tracker.n_timeouts, tracker.n_frame_errs, tracker.checked, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: uart_8n1_transceiver.f
rtl/uart_pkg.sv
rtl/uart_tx.sv
rtl/uart_rx.sv
rtl/uart_8n1_transceiver.sv
test/uart_8n1_transceiver_tb.sv
